### design/nfsa_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the next-fit slot allocator. No dependencies.
`timescale 1ns / 1ps

package nfsa_pkg;

  // Pool geometry: the live map is held as rows of WORD_W bits.
  localparam int SLOT_COUNT = 1024;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int ROWS       = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W      = ROW_W + BIT_W;
  localparam int PTR_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Port field widths.
  localparam int HANDLE_W = 11;
  localparam int GRANT_W  = 10;
  localparam int STATUS_W = 3;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 3'd0,
    ST_FULL         = 3'd1,
    ST_INIT_FAILED  = 3'd2,
    ST_FREED        = 3'd3,
    ST_FREE_IGNORED = 3'd4
  } status_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted request
    logic rd_scan;      // read the row under search
    logic scan;         // look for a free slot in the row just read
    logic rd_free;      // read the row holding the handle
    logic check;        // test and clear the handle's live bit
    logic emit_full;    // report a full pool
    logic emit_ignore;  // report an ignored free
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pool_full;
    logic handle_oor;
    logic found;
  } stat_t;

endpackage

### design/nfsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module nfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### design/nfsa_ctrl.sv
// Controller state machine of the slot allocator: sequences row reads,
// scans and commits. Depends on nfsa_pkg.
`timescale 1ns / 1ps

module nfsa_ctrl
  import nfsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_func,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ALLOC,
    S_SCAN,
    S_RD_FREE,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   busy_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FUNC_ALLOC) begin
            if (stat.pool_full) begin
              cmd.emit_full = 1'b1;
            end else begin
              cmd.load  = 1'b1;
              state_nxt = S_RD_ALLOC;
            end
          end else begin
            if (stat.handle_oor) begin
              cmd.emit_ignore = 1'b1;
            end else begin
              cmd.load  = 1'b1;
              state_nxt = S_RD_FREE;
            end
          end
        end
      end
      S_RD_ALLOC: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = stat.found ? S_IDLE : S_RD_ALLOC;
      end
      S_RD_FREE: begin
        cmd.rd_free = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // State and registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

### design/nfsa_dp.sv
// Datapath of the slot allocator: live-map RAM with row valid flags,
// search pointer, used count, free-bit search and result registers.
// Depends on nfsa_pkg and nfsa_ram.
`timescale 1ns / 1ps

module nfsa_dp
  import nfsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [HANDLE_W-1:0] in_slot_handle,
  input  logic                in_init_ok,
  output stat_t               stat,
  output logic                out_valid,
  output logic [GRANT_W-1:0]  out_granted_slot,
  output logic [STATUS_W-1:0] out_status
);

  // Request and search state.
  logic [PTR_W-1:0] req_handle_r;
  logic             req_init_ok_r;
  logic [ROW_W-1:0] scan_row_r;
  logic             first_r;
  logic [ROW_W-1:0] rd_row_r;
  logic [PTR_W-1:0] ptr_r;
  logic [CNT_W-1:0] used_r;
  logic [ROWS-1:0]  row_valid_r;

  // Result registers.
  logic                out_valid_r;
  logic [GRANT_W-1:0]  out_slot_r;
  status_code_t        out_status_r;

  // Decoded positions and RAM signals.
  logic [IDX_W-1:0]  ptr_ext;
  logic [IDX_W-1:0]  hdl_ext;
  logic [ROW_W-1:0]  ptr_row;
  logic [BIT_W-1:0]  ptr_off;
  logic [ROW_W-1:0]  hdl_row;
  logic [BIT_W-1:0]  hdl_off;
  logic [ROW_W-1:0]  next_row;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] row_data;
  logic [WORD_W-1:0] occupied;
  logic              found;
  logic [BIT_W-1:0]  ffz_idx;
  logic [IDX_W-1:0]  found_slot;
  logic              hdl_live;
  logic              do_grant;
  logic              do_free;

  assign ptr_ext  = IDX_W'(ptr_r);
  assign hdl_ext  = IDX_W'(req_handle_r);
  assign ptr_row  = ptr_ext[IDX_W-1:BIT_W];
  assign ptr_off  = ptr_ext[BIT_W-1:0];
  assign hdl_row  = hdl_ext[IDX_W-1:BIT_W];
  assign hdl_off  = hdl_ext[BIT_W-1:0];
  assign next_row = (scan_row_r == ROW_W'(ROWS - 1)) ? '0 : scan_row_r + 1'b1;

  // Row read: the handle's row for a free, otherwise the row under search.
  assign ram_re    = cmd.rd_scan | cmd.rd_free;
  assign ram_raddr = cmd.rd_free ? hdl_row : scan_row_r;

  // A row never written since reset reads as all free.
  assign row_data = row_valid_r[rd_row_r] ? ram_rdata : '0;

  // Mark slots that cannot be taken: live ones, those past the pool end,
  // and on the first visit those below the pointer.
  always_comb begin
    logic [IDX_W-1:0] idx;
    occupied = '0;
    idx      = '0;
    for (int b = 0; b < WORD_W; b++) begin
      idx         = {rd_row_r, BIT_W'(b)};
      occupied[b] = row_data[b] | (32'(idx) >= 32'(SLOT_COUNT)) |
                    (first_r & (BIT_W'(b) < ptr_off));
    end
  end

  // Lowest free bit of the row.
  always_comb begin
    found   = 1'b0;
    ffz_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!occupied[b]) begin
        found   = 1'b1;
        ffz_idx = BIT_W'(b);
      end
    end
  end

  assign found_slot = {rd_row_r, ffz_idx};
  assign hdl_live   = row_data[hdl_off];
  assign do_grant   = cmd.scan & found & req_init_ok_r;
  assign do_free    = cmd.check & hdl_live;

  // Live-map write-back: set the granted bit or clear the freed one.
  assign ram_we    = do_grant | do_free;
  assign ram_wdata = do_grant ? (row_data | (WORD_W'(1) << ffz_idx))
                              : (row_data & ~(WORD_W'(1) << hdl_off));

  nfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_live_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (rd_row_r),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Status for the controller.
  assign stat.pool_full  = (used_r == CNT_W'(SLOT_COUNT));
  assign stat.handle_oor = (32'(in_slot_handle) >= 32'(SLOT_COUNT));
  assign stat.found      = found;

  // Control state: pointer, count, row valid flags, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      used_r      <= '0;
      row_valid_r <= '0;
      first_r     <= 1'b0;
      scan_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_full | cmd.emit_ignore | (cmd.scan & found) | cmd.check;
      if (cmd.load) begin
        scan_row_r <= ptr_row;
        first_r    <= 1'b1;
      end
      if (cmd.scan && !found) begin
        scan_row_r <= next_row;
        first_r    <= 1'b0;
      end
      if (cmd.scan && found) begin
        ptr_r <= PTR_W'(found_slot);
      end
      if (do_grant) begin
        used_r <= used_r + 1'b1;
      end
      if (do_free) begin
        used_r <= used_r - 1'b1;
      end
      if (ram_we) begin
        row_valid_r[rd_row_r] <= 1'b1;
      end
    end
  end

  // Request capture, read row tracking and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_handle_r  <= PTR_W'(in_slot_handle);
      req_init_ok_r <= in_init_ok;
    end
    if (ram_re) begin
      rd_row_r <= ram_raddr;
    end
    if (cmd.emit_full) begin
      out_slot_r   <= '0;
      out_status_r <= ST_FULL;
    end else if (cmd.emit_ignore) begin
      out_slot_r   <= '0;
      out_status_r <= ST_FREE_IGNORED;
    end else if (cmd.scan && found) begin
      out_slot_r   <= req_init_ok_r ? GRANT_W'(found_slot) : '0;
      out_status_r <= req_init_ok_r ? ST_ALLOCATED : ST_INIT_FAILED;
    end else if (cmd.check) begin
      out_slot_r   <= '0;
      out_status_r <= hdl_live ? ST_FREED : ST_FREE_IGNORED;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

endmodule

### design/next_fit_slot_allocator.sv
// Per request: a full-pool allocate or an out-of-range free is answered from idle; a free
// reads the handle's row (single RAM read), then checks it; an allocate reads and scans
// one live-map row after another (1 to ROWS+1 rows of 32 slots) until a slot is free.
// busy is low again in the cycle the result strobe is high, so the next request can start then.
// Reset is synchronous: per-row valid flags clear the live map at once, no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module next_fit_slot_allocator
  import nfsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [HANDLE_W-1:0] in_slot_handle,
  input  logic                in_init_ok,
  output logic                out_valid,
  output logic [GRANT_W-1:0]  out_granted_slot,
  output logic [STATUS_W-1:0] out_status
);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  nfsa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Datapath.
  nfsa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_slot_handle   (in_slot_handle),
    .in_init_ok       (in_init_ok),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

  // An accepted request either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // A result only follows an accepted request or work in progress.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start || busy))
    else $error("result strobe without a request");

  // Only a successful allocation carries a slot number.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_ALLOCATED)) |-> (out_granted_slot == '0))
    else $error("non-zero slot on a result other than allocated");

endmodule
